// ===== hw/rtl/scmr_pkg.sv =====
package scmr_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned SIGN_W      = 8;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = 3;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic signed [SIGN_W-1:0] SIGN_POS = 8'sd1;
  localparam logic signed [SIGN_W-1:0] SIGN_NEG = -8'sd1;

  typedef enum logic {
    FUNC_ROW   = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_FIRST_NEG = 2'd0,
    KIND_LAST_POS  = 2'd1,
    KIND_MISMATCH  = 2'd2,
    KIND_BAD_SIGN  = 2'd3
  } kind_e;

  localparam logic REG_POS_ONLY = 1'b0;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic              mism;
    logic              last;
  } result_t;

endpackage

// ===== hw/rtl/sign_collapsing_row_merger_unit.sv =====
// A word reaches the input register on acceptance; its results are written into the
// output queue register when it fires, and the first one is offered from there.
// Throughput: one input word per cycle while each word yields at most one result that is taken;
// the four-entry output queue, which must hold room for three results, sets the stall.
// Reset: rst_ni asynchronously clears group state, the queue count and positive_only_mode.
module sign_collapsing_row_merger_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row_key, row_sign, row_id
  input  logic [scmr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_kind, emitted_id, count_mismatch, zero padding
  output logic [scmr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scmr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [scmr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [scmr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import scmr_pkg::*;

  logic                     pos_only_q;
  logic                     in_valid_q;
  func_e                    func_q;
  logic [KEY_W-1:0]         key_q;
  logic signed [SIGN_W-1:0] sign_q;
  logic [ID_W-1:0]          id_q;

  logic [KEY_W-1:0]         gkey_q;
  logic                     gopen_q;
  logic [COUNT_BITS-1:0]    pcnt_q, pcnt_d;
  logic [COUNT_BITS-1:0]    ncnt_q, ncnt_d;
  logic                     lsp_q, lsp_d;
  logic [ID_W-1:0]          fneg_q;
  logic [ID_W-1:0]          lpos_q;

  result_t                  queue_q [QUEUE_DEPTH];
  result_t                  queue_d [QUEUE_DEPTH];
  logic [QCNT_W-1:0]        cnt_q, cnt_d;

  logic                     room, fire, pop, accept;
  logic                     is_row, is_flush, key_match, do_coll, keep;
  logic                     sign_pos, sign_neg, bad_v;
  logic [COUNT_BITS-1:0]    diff, base_p, base_n;
  logic                     nonempty, mism, emit0, emit1, emit2;
  logic [1:0]               cnum, nres;
  result_t                  k0, k1, k2, kbad;
  result_t                  res [3];
  logic [QCNT_W-1:0]        base;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POS_ONLY);
  assign prdata = (paddr[2] == REG_POS_ONLY) ? {{(APB_DATA_W-1){1'b0}}, pos_only_q} : '0;

  assign room          = (cnt_q <= QCNT_W'(1));
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {{(OUT_TDATA_W-ID_W-3){1'b0}}, queue_q[0].mism, queue_q[0].id,
                          queue_q[0].kind};
  assign m_axis_tlast  = queue_q[0].last;

  // collapse of the current group
  assign is_flush  = (func_q == FUNC_FLUSH);
  assign is_row    = !is_flush;
  assign key_match = (key_q == gkey_q);
  assign do_coll   = gopen_q && (is_flush || !key_match);
  assign diff      = (pcnt_q >= ncnt_q) ? (pcnt_q - ncnt_q) : (ncnt_q - pcnt_q);
  assign mism      = |diff[COUNT_BITS-1:1];
  assign nonempty  = do_coll && ((pcnt_q != '0) || (ncnt_q != '0)) &&
                     (lsp_q || (pcnt_q != ncnt_q));
  assign emit0     = nonempty && (pcnt_q <= ncnt_q) && !pos_only_q;
  assign emit1     = nonempty && (pcnt_q >= ncnt_q);
  assign emit2     = nonempty && !emit0 && !emit1 && mism;

  assign sign_pos  = (sign_q == SIGN_POS);
  assign sign_neg  = (sign_q == SIGN_NEG);
  assign bad_v     = is_row && !sign_pos && !sign_neg;

  assign k0   = '{kind: KIND_FIRST_NEG, id: fneg_q, mism: mism, last: 1'b0};
  assign k1   = '{kind: KIND_LAST_POS, id: lpos_q, mism: mism, last: 1'b0};
  assign k2   = '{kind: KIND_MISMATCH, id: '0, mism: 1'b1, last: 1'b0};
  assign kbad = '{kind: KIND_BAD_SIGN, id: id_q, mism: 1'b0, last: 1'b0};

  assign cnum   = 2'(emit0) + 2'(emit1) + 2'(emit2);
  assign nres   = cnum + 2'(bad_v);
  assign res[0] = (cnum != 2'd0) ? (emit0 ? k0 : (emit1 ? k1 : k2)) : kbad;
  assign res[1] = (cnum == 2'd2) ? k1 : kbad;
  assign res[2] = kbad;

  // group counters
  assign keep   = gopen_q && key_match;
  assign base_p = keep ? pcnt_q : '0;
  assign base_n = keep ? ncnt_q : '0;

  always_comb begin
    pcnt_d = pcnt_q;
    ncnt_d = ncnt_q;
    lsp_d  = lsp_q;
    if (is_flush) begin
      pcnt_d = '0;
      ncnt_d = '0;
    end else begin
      pcnt_d = base_p;
      ncnt_d = base_n;
      if (sign_pos) begin
        if (base_p != '1) pcnt_d = base_p + COUNT_BITS'(1);
        lsp_d = 1'b1;
      end else if (sign_neg) begin
        if (base_n != '1) ncnt_d = base_n + COUNT_BITS'(1);
        lsp_d = 1'b0;
      end
    end
  end

  // output queue: shift on pop, append pushed results behind
  assign base = cnt_q - QCNT_W'(pop);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      queue_d[i] = pop ? queue_q[i+1] : queue_q[i];
    end
    queue_d[QUEUE_DEPTH-1] = queue_q[QUEUE_DEPTH-1];
    if (fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) begin
          queue_d[2'(base + QCNT_W'(i))]      = res[i];
          queue_d[2'(base + QCNT_W'(i))].last = (2'(i) == nres - 2'd1);
        end
      end
    end
    cnt_d = base + (fire ? QCNT_W'(nres) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_only_q <= 1'b0;
      in_valid_q <= 1'b0;
      gopen_q    <= 1'b0;
      gkey_q     <= '0;
      pcnt_q     <= '0;
      ncnt_q     <= '0;
      lsp_q      <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cfg_wr) pos_only_q <= pwdata[0];
      if (accept) in_valid_q <= 1'b1;
      else if (fire) in_valid_q <= 1'b0;
      if (fire) begin
        pcnt_q <= pcnt_d;
        ncnt_q <= ncnt_d;
        lsp_q  <= lsp_d;
        if (is_flush) begin
          gopen_q <= 1'b0;
        end else begin
          gopen_q <= 1'b1;
          gkey_q  <= key_q;
        end
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(s_axis_tuser);
      key_q  <= s_axis_tdata[KEY_W-1:0];
      sign_q <= s_axis_tdata[KEY_W+SIGN_W-1:KEY_W];
      id_q   <= s_axis_tdata[KEY_W+SIGN_W+ID_W-1:KEY_W+SIGN_W];
    end
    if (fire && is_row) begin
      if (sign_pos) lpos_q <= id_q;
      if (sign_neg && (base_n == '0)) fneg_q <= id_q;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

endmodule

// ===== hw/rtl/scmr_checker.sv =====
module scmr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [scmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             pready
);
  import scmr_pkg::*;

  logic [1:0] kind;
  assign kind = m_axis_tdata[1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_mismatch_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KIND_MISMATCH) |->
      m_axis_tdata[ID_W+1:2] == '0 && m_axis_tdata[ID_W+2])
    else $error("mismatch-only word without flag or with id");

  a_bad_sign_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KIND_BAD_SIGN) |-> !m_axis_tdata[ID_W+2] && m_axis_tlast)
    else $error("invalid-sign word carries mismatch or is not last");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind sign_collapsing_row_merger_unit scmr_checker u_scmr_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  import scmr_pkg::*;

  typedef struct {
    func_e             func;
    logic [KEY_W-1:0]  key;
    logic [SIGN_W-1:0] sign;
    logic [ID_W-1:0]   id;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr   = '0;
  logic [APB_DATA_W-1:0]  pwdata  = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  sign_collapsing_row_merger_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // merger state mirror
  logic [KEY_W-1:0] grp_key      = '0;
  logic             grp_open     = 1'b0;
  logic [31:0]      pos_cnt      = '0;
  logic [31:0]      neg_cnt      = '0;
  logic             last_was_pos = 1'b0;
  logic [ID_W-1:0]  first_neg_id = '0;
  logic [ID_W-1:0]  last_pos_id  = '0;
  logic             pos_only     = 1'b0;

  row_t    pending_rows[$];
  row_t    in_flight;
  result_t step_results[$];
  result_t due_results[$];

  int rows_sent  = 0;
  int rows_taken = 0;
  int errors     = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int pat_left   = 0;
  logic [7:0] stall_pat = 8'hFF;
  logic hold_off    = 1'b0;
  logic squeeze_go  = 1'b0;

  task automatic note_error(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endtask

  task automatic add_result(input kind_e kind, input logic [ID_W-1:0] id, input logic mism);
    result_t res;
    res.kind = kind;
    res.id   = id;
    res.mism = mism;
    res.last = 1'b0;
    step_results.push_back(res);
  endtask

  task automatic collapse_group();
    logic mism;
    int   made;
    made = 0;
    if ((pos_cnt != 0 || neg_cnt != 0) && (last_was_pos || pos_cnt != neg_cnt)) begin
      mism = (pos_cnt > neg_cnt) ? (pos_cnt - neg_cnt > 1) : (neg_cnt - pos_cnt > 1);
      if (pos_cnt <= neg_cnt && !pos_only) begin
        add_result(KIND_FIRST_NEG, first_neg_id, mism);
        made++;
      end
      if (pos_cnt >= neg_cnt) begin
        add_result(KIND_LAST_POS, last_pos_id, mism);
        made++;
      end
      if (made == 0 && mism) add_result(KIND_MISMATCH, '0, 1'b1);
    end
  endtask

  task automatic merge_row(input row_t r);
    step_results.delete();
    if (r.func == FUNC_FLUSH) begin
      if (grp_open) collapse_group();
      grp_open = 1'b0;
      pos_cnt  = '0;
      neg_cnt  = '0;
    end else begin
      if (!grp_open || r.key != grp_key) begin
        if (grp_open) collapse_group();
        pos_cnt = '0;
        neg_cnt = '0;
      end
      grp_open = 1'b1;
      grp_key  = r.key;
      if (r.sign == SIGN_POS) begin
        if (pos_cnt != '1) pos_cnt++;
        last_was_pos = 1'b1;
        last_pos_id  = r.id;
      end else if (r.sign == SIGN_NEG) begin
        if (neg_cnt == 0) first_neg_id = r.id;
        if (neg_cnt != '1) neg_cnt++;
        last_was_pos = 1'b0;
      end else begin
        add_result(KIND_BAD_SIGN, r.id, 1'b0);
      end
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) due_results.push_back(step_results[i]);
  endtask

  // sender: bursts with gaps, hold the word while stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        merge_row(in_flight);
        rows_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          in_flight = pending_rows.pop_front();
          s_axis_tdata  <= {in_flight.id, in_flight.sign, in_flight.key};
          s_axis_tuser  <= in_flight.func;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each word, stall on a rotating pattern
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tdata[1:0]);
        got.id   = m_axis_tdata[33:2];
        got.mism = m_axis_tdata[34];
        got.last = m_axis_tlast;
        if (due_results.size() == 0) begin
          note_error($sformatf("unexpected word: kind %0d id %h mism %0b last %0b",
                               got.kind, got.id, got.mism, got.last));
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.id !== want.id ||
              got.mism !== want.mism || got.last !== want.last)
            note_error($sformatf(
              "word mismatch: expected kind %0d id %h mism %0b last %0b, got %0d %h %0b %0b",
              want.kind, want.id, want.mism, want.last,
              got.kind, got.id, got.mism, got.last));
        end
      end
      if (pat_left == 0) begin
        pat_left  = $urandom_range(8, 64);
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      end else begin
        pat_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      m_axis_tready <= !hold_off && stall_pat[0];
    end
  end

  // long hold-off while the sender keeps offering words
  initial begin
    wait (squeeze_go);
    repeat (20) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

  task automatic push_row(input func_e f, input logic [KEY_W-1:0] k,
                          input logic [SIGN_W-1:0] s, input logic [ID_W-1:0] id);
    row_t r;
    r.func = f;
    r.key  = k;
    r.sign = s;
    r.id   = id;
    pending_rows.push_back(r);
    rows_sent++;
  endtask

  task automatic program_pos_only(input logic mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_POS_ONLY, 2'b00};
    pwdata  <= APB_DATA_W'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pos_only = mode;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_DATA_W'(mode))
      note_error($sformatf("register read: expected %h, got %h", APB_DATA_W'(mode), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rows_taken != rows_sent || due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n_rows);
    int left;
    int pick;
    int size;
    int bias;
    logic [KEY_W-1:0]  key;
    logic [SIGN_W-1:0] sign;
    left = n_rows;
    key  = '0;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_row(FUNC_FLUSH, {$urandom, $urandom}, 8'($urandom), $urandom);
        left--;
      end else if (pick < 14) begin
        push_row(FUNC_ROW, {$urandom, $urandom}, 8'($urandom), $urandom);
        left--;
      end else begin
        if (pick >= 40) key = {$urandom, $urandom};
        else if (pick >= 20) key = KEY_W'($urandom_range(0, 7));
        size = $urandom_range(1, 6);
        bias = $urandom_range(0, 100);
        repeat (size) begin
          if ($urandom_range(0, 24) == 0) sign = 8'($urandom);
          else sign = ($urandom_range(1, 100) <= bias) ? SIGN_POS : SIGN_NEG;
          push_row(FUNC_ROW, key, sign, $urandom);
        end
        left -= size;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    program_pos_only(1'b0);

    push_row(FUNC_FLUSH, '1, 8'h80, '1);
    push_row(FUNC_ROW, '0, SIGN_POS, '0);
    push_row(FUNC_ROW, '0, SIGN_POS, 32'd1);
    push_row(FUNC_ROW, 64'd1, SIGN_NEG, '1);
    push_row(FUNC_ROW, 64'd1, SIGN_POS, 32'd5);
    push_row(FUNC_ROW, 64'd2, SIGN_NEG, 32'd6);
    push_row(FUNC_ROW, 64'd2, SIGN_NEG, 32'd8);
    push_row(FUNC_ROW, 64'd2, SIGN_NEG, 32'd9);
    push_row(FUNC_ROW, 64'd2, SIGN_POS, 32'd10);
    push_row(FUNC_ROW, 64'd3, SIGN_POS, 32'd11);
    push_row(FUNC_ROW, 64'd3, SIGN_NEG, 32'd12);
    push_row(FUNC_ROW, 64'd4, 8'h00, 32'd13);
    push_row(FUNC_ROW, 64'd4, 8'h7F, 32'd14);
    push_row(FUNC_ROW, 64'd4, 8'h02, 32'd15);
    push_row(FUNC_ROW, 64'd4, 8'h80, 32'd16);
    push_row(FUNC_ROW, 64'd4, 8'hFE, 32'd17);
    push_row(FUNC_ROW, 64'd4, SIGN_POS, 32'd18);
    push_row(FUNC_ROW, '1, 8'h55, 32'h5555_5555);
    push_row(FUNC_ROW, '1, SIGN_NEG, 32'hAAAA_AAAA);
    push_row(FUNC_FLUSH, '0, '0, '0);
    push_row(FUNC_FLUSH, '0, SIGN_POS, '0);
    push_row(FUNC_ROW, 64'hAAAA_AAAA_AAAA_AAAA, SIGN_NEG, 32'd22);
    push_row(FUNC_ROW, 64'hAAAA_AAAA_AAAA_AAAA, SIGN_POS, 32'd23);
    push_row(FUNC_ROW, 64'h5555_5555_5555_5555, 8'h7E, 32'd24);
    push_row(FUNC_FLUSH, '1, SIGN_NEG, '1);
    wait_idle();

    program_pos_only(1'b1);
    push_row(FUNC_ROW, 64'd7, SIGN_NEG, 32'd30);
    push_row(FUNC_ROW, 64'd7, SIGN_NEG, 32'd31);
    push_row(FUNC_ROW, 64'd7, SIGN_NEG, 32'd32);
    push_row(FUNC_ROW, 64'd7, SIGN_POS, 32'd33);
    push_row(FUNC_ROW, 64'd8, SIGN_NEG, 32'd34);
    push_row(FUNC_FLUSH, '0, '0, '0);
    push_row(FUNC_ROW, 64'd9, SIGN_POS, 32'd35);
    push_row(FUNC_ROW, 64'd9, SIGN_NEG, 32'd36);
    push_row(FUNC_ROW, 64'd9, SIGN_POS, 32'd37);
    push_row(FUNC_ROW, 64'd10, SIGN_NEG, 32'd38);
    push_row(FUNC_ROW, 64'd10, SIGN_POS, 32'd39);
    push_row(FUNC_FLUSH, '0, '0, '0);
    queue_random(110);
    wait_idle();

    program_pos_only(1'b0);
    queue_random(110);
    squeeze_go = 1'b1;
    wait_idle();

    program_pos_only(1'b1);
    queue_random(80);
    push_row(FUNC_FLUSH, '0, '0, '0);
    wait_idle();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
